FILE: rtl/core/owpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owpa_pkg: shared types and codes of the ordered worker pool allocator
// Field widths, command and status codes, and the structs passed between
// the top level and the table cells.
// ----------------------------------------------------------------------------
package owpa_pkg;

    localparam int ID_W     = 31;
    localparam int CNT_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 32;   // pool_id padded to whole bytes
    localparam int M_DATA_W = 48;   // granted_id, free_count, entry_count padded

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE_FREE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic            valid;
        logic            free;
        logic [ID_W-1:0] id;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             eval;    // register match flags this cycle
        logic             apply;   // update entries this cycle
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  key;
    } t_cell_ctrl;

endpackage : owpa_pkg
`default_nettype wire

FILE: rtl/core/ordered_worker_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_worker_pool_allocator: insertion-ordered pool of worker ids
// Add appends a free id, remove deletes the oldest matching id and closes
// the gap, allocate grants the oldest free id. Each request gives one result.
// ----------------------------------------------------------------------------
//  channel   dir   tdata (low bit up)                         tuser
//  s         in    pool_id[30:0], pad                         command[1:0]
//  m         out   granted_id[30:0], free_count[4:0],         status[1:0]
//                  entry_count[4:0], pad
//
//  A request first compares the key or free flag in every cell and registers
//  the match flags (MATCH), then resolves the oldest hit through the prefix
//  network and updates the cells (APPLY). A new request is taken in the
//  cycle the previous result is loaded. The result register holds while
//  i_m_tready is low; a request waiting to update holds until it drains.
//  Reset empties the pool.
// ----------------------------------------------------------------------------
module ordered_worker_pool_allocator
    import owpa_pkg::*;
#(
    parameter int POOL_DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire  [S_DATA_W-1:0]  i_s_tdata,    // pool_id, pad
    input  wire  [CMD_W-1:0]     i_s_tuser,    // command
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [M_DATA_W-1:0]  o_m_tdata,    // granted_id, free_count, entry_count, pad
    output logic [STAT_W-1:0]    o_m_tuser     // status
);

    localparam int OCC_W = $clog2(POOL_DEPTH + 1);
    localparam int PAD_W = M_DATA_W - ID_W - 2 * CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_key;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [OCC_W-1:0]  r_free_cnt, n_free_cnt;

    logic              r_m_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ID_W-1:0]   r_granted, n_granted;
    logic [CNT_W-1:0]  r_free_out, r_entry_out;

    logic              s_accept;
    logic              apply;
    t_cell_ctrl        cell_ctrl;

    t_entry            entry   [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] valid_vec, free_vec, match_vec, upto_vec, first_vec;

    logic              any_hit;
    logic              removed_free;
    logic              full;

    // ---------------------------------------------------------------- control
    assign apply      = (r_state == ST_APPLY) && (!r_m_valid || i_m_tready);
    assign o_s_tready = (r_state == ST_IDLE) || apply;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_accept) n_state = ST_MATCH;
            ST_MATCH: n_state = ST_APPLY;
            ST_APPLY: begin
                if (apply) begin
                    n_state = s_accept ? ST_MATCH : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_s_tuser;
            r_key <= i_s_tdata[ID_W-1:0];
        end
    end

    assign cell_ctrl.eval  = (r_state == ST_MATCH);
    assign cell_ctrl.apply = apply;
    assign cell_ctrl.cmd   = r_cmd;
    assign cell_ctrl.key   = r_key;

    // ------------------------------------------------------------ cell chain
    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
            t_entry right;
            logic   left_valid;

            if (g == 0) begin : g_first
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_valid = valid_vec[g-1];
            end

            if (g == POOL_DEPTH - 1) begin : g_last
                assign right = '0;
            end else begin : g_inner
                assign right = entry[g+1];
            end

            owpa_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_left_valid (left_valid),
                .i_right      (right),
                .i_hit_upto   (upto_vec[g]),
                .i_hit_first  (first_vec[g]),
                .o_entry      (entry[g]),
                .o_match      (match_vec[g])
            );

            assign valid_vec[g] = entry[g].valid;
            assign free_vec[g]  = entry[g].free;
        end
    endgenerate

    owpa_prefix #(
        .N (POOL_DEPTH)
    ) u_prefix (
        .i_match (match_vec),
        .o_upto  (upto_vec)
    );

    assign first_vec    = upto_vec & ~(upto_vec << 1);
    assign any_hit      = upto_vec[POOL_DEPTH-1];
    assign removed_free = |(first_vec & free_vec);
    assign full         = (r_occ == OCC_W'(POOL_DEPTH));

    // ---------------------------------------------------------------- result
    always_comb begin
        n_granted = '0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            n_granted = n_granted | (first_vec[i] ? entry[i].id : '0);
        end
        if (r_cmd != CMD_ALLOC) begin
            n_granted = '0;
        end
    end

    always_comb begin
        n_status   = STAT_OK;
        n_occ      = r_occ;
        n_free_cnt = r_free_cnt;
        unique case (r_cmd)
            CMD_ADD: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_occ      = r_occ + OCC_W'(1);
                    n_free_cnt = r_free_cnt + OCC_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!any_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_occ      = r_occ - OCC_W'(1);
                    n_free_cnt = r_free_cnt - OCC_W'(removed_free);
                end
            end
            CMD_ALLOC: begin
                if (!any_hit) begin
                    n_status = STAT_NONE_FREE;
                end else begin
                    n_free_cnt = r_free_cnt - OCC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_free_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (apply) begin
                r_occ      <= n_occ;
                r_free_cnt <= n_free_cnt;
                r_m_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_free_out  <= CNT_W'(n_free_cnt);
            r_entry_out <= CNT_W'(n_occ);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_entry_out, r_free_out, r_granted};

    // ------------------------------------------------------------ assertions
`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(POOL_DEPTH))
        else $error("occupancy above pool depth");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_occ)
        else $error("free count above occupancy");

    a_occ_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_occ))
        else $error("occupied cells disagree with occupancy");

    a_free_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(free_vec & valid_vec) == int'(r_free_cnt))
        else $error("free cells disagree with free count");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |-> $onehot0(first_vec))
        else $error("more than one oldest hit");
`endif

endmodule : ordered_worker_pool_allocator
`default_nettype wire

FILE: rtl/core/owpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owpa_cell: one table slot of the worker pool
// Holds one entry, registers its own match flag and, on update, appends,
// takes the right neighbor's entry to close a gap, or goes busy.
// ----------------------------------------------------------------------------
module owpa_cell
    import owpa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire         i_left_valid,   // left neighbor occupied (tied high for slot 0)
    input  wire t_entry i_right,        // right neighbor entry (empty past the last slot)
    input  wire         i_hit_upto,     // oldest hit is at or left of this slot
    input  wire         i_hit_first,    // this slot is the oldest hit
    output t_entry      o_entry,
    output logic        o_match
);

    logic            r_valid, n_valid;
    logic            r_free,  n_free;
    logic [ID_W-1:0] r_id,    n_id;
    logic            r_match, n_match;

    always_comb begin
        n_valid = r_valid;
        n_free  = r_free;
        n_id    = r_id;
        if (i_ctrl.apply) begin
            unique case (i_ctrl.cmd)
                CMD_ADD: begin
                    // first empty slot takes the new id
                    if (!r_valid && i_left_valid) begin
                        n_valid = 1'b1;
                        n_free  = 1'b1;
                        n_id    = i_ctrl.key;
                    end
                end
                CMD_REMOVE: begin
                    // shift left from the removed slot on
                    if (i_hit_upto) begin
                        n_valid = i_right.valid;
                        n_free  = i_right.free;
                        n_id    = i_right.id;
                    end
                end
                CMD_ALLOC: begin
                    if (i_hit_first) begin
                        n_free = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctrl.eval) begin
            if (i_ctrl.cmd == CMD_REMOVE) begin
                n_match = r_valid && (r_id == i_ctrl.key);
            end else begin
                n_match = r_valid && r_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_free  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_free  <= n_free;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.free  = r_free;
    assign o_entry.id    = r_id;
    assign o_match       = r_match;

endmodule : owpa_cell
`default_nettype wire

FILE: rtl/core/owpa_prefix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owpa_prefix: inclusive prefix OR over the cell match flags
// Log-depth network; bit i is set when any slot at or below i matched.
// ----------------------------------------------------------------------------
module owpa_prefix #(
    parameter int N = 16
) (
    input  wire  [N-1:0] i_match,
    output logic [N-1:0] o_upto
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] lvl [0:LEVELS];

    assign lvl[0] = i_match;

    genvar k;
    generate
        for (k = 0; k < LEVELS; k++) begin : g_lvl
            assign lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
        end
    endgenerate

    assign o_upto = lvl[LEVELS];

endmodule : owpa_prefix
`default_nettype wire

FILE: tb/ordered_worker_pool_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_worker_pool_allocator_test: self-checking bench for the worker pool
// Drives add, remove, allocate and unused-code requests through the slave
// stream, keeps an ordered copy of the pool to predict each result, and
// compares every result on the master stream field by field, in order.
// ----------------------------------------------------------------------------
module ordered_worker_pool_allocator_test;
    import owpa_pkg::*;

    localparam int POOL_DEPTH = 16;
    localparam int FREE_LSB   = ID_W;
    localparam int ENTRY_LSB  = ID_W + CNT_W;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   granted;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  entry_cnt;
    } pool_result_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata  = '0;   // pool_id, pad
    logic [CMD_W-1:0]     i_s_tuser  = '0;   // command
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;         // granted_id, free_count, entry_count, pad
    logic [STAT_W-1:0]    o_m_tuser;         // status

    // predicted pool contents, oldest entry first
    logic [ID_W-1:0] pool_ids[$];
    bit              pool_free[$];

    pool_result_t awaited_results[$];
    int           error_count  = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;

    ordered_worker_pool_allocator #(
        .POOL_DEPTH (POOL_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("FAIL ordered_worker_pool_allocator");
        $finish;
    end

    function automatic pool_result_t apply_pool_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [ID_W-1:0] wid);
        pool_result_t res;
        int hit;
        int nfree;
        res = '0;
        hit = -1;
        nfree = 0;
        case (cmd)
            CMD_ADD: begin
                if (pool_ids.size() >= POOL_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    pool_ids.push_back(wid);
                    pool_free.push_back(1'b1);
                end
            end
            CMD_REMOVE: begin
                for (int i = 0; i < pool_ids.size() && hit < 0; i++)
                    if (pool_ids[i] == wid) hit = i;
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    // busy or free, the oldest match goes
                    pool_ids.delete(hit);
                    pool_free.delete(hit);
                end
            end
            CMD_ALLOC: begin
                for (int i = 0; i < pool_free.size() && hit < 0; i++)
                    if (pool_free[i]) hit = i;
                if (hit < 0) begin
                    res.status = STAT_NONE_FREE;
                end else begin
                    pool_free[hit] = 1'b0;
                    res.granted = pool_ids[hit];
                end
            end
            default: ;
        endcase
        foreach (pool_free[i])
            if (pool_free[i]) nfree++;
        res.free_cnt  = nfree[CNT_W-1:0];
        res.entry_cnt = CNT_W'(pool_ids.size());
        return res;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0:       return '0;
            1:       return ID_MAX;
            2, 3, 4: return ID_W'($urandom_range(1, 6));   // narrow range to force duplicates
            default: return raw[ID_W-1:0];
        endcase
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] wid);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-ID_W){1'b0}}, wid};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        awaited_results.push_back(apply_pool_command(cmd, wid));
    endtask

    // hold the sender off until every outstanding result is back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic check_result();
        pool_result_t got;
        pool_result_t want;
        got.status    = o_m_tuser;
        got.granted   = o_m_tdata[ID_W-1:0];
        got.free_cnt  = o_m_tdata[FREE_LSB +: CNT_W];
        got.entry_cnt = o_m_tdata[ENTRY_LSB +: CNT_W];
        if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, actual status %0d granted %h free %0d entries %0d",
                     $time, got.status, got.granted, got.free_cnt, got.entry_cnt);
            error_count++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            error_count++;
        end
        if (got.granted !== want.granted) begin
            $display("%0t: granted_id expected %h actual %h", $time, want.granted, got.granted);
            error_count++;
        end
        if (got.free_cnt !== want.free_cnt) begin
            $display("%0t: free_count expected %0d actual %0d",
                     $time, want.free_cnt, got.free_cnt);
            error_count++;
        end
        if (got.entry_cnt !== want.entry_cnt) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_cnt, got.entry_cnt);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result();
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic test_directed();
        src_idle_pct = 30;
        snk_idle_pct = 30;
        // empty pool corner cases
        send_request(CMD_ALLOC, '0);
        send_request(CMD_REMOVE, 31'd5);
        send_request(CMD_NOP, ID_MAX);
        // fill to the brim with extremes and a duplicate, then overflow
        send_request(CMD_ADD, '0);
        send_request(CMD_ADD, ID_MAX);
        send_request(CMD_ADD, 31'h2AAA_AAAA);
        send_request(CMD_ADD, '0);
        for (int i = 4; i < POOL_DEPTH; i++)
            send_request(CMD_ADD, ID_W'(31'h5555_5550 + i));
        send_request(CMD_ADD, 31'd77);
        send_request(CMD_ALLOC, ID_MAX);
        send_request(CMD_ALLOC, '0);
        // oldest id 0 is busy now and still goes away
        send_request(CMD_REMOVE, '0);
        send_request(CMD_REMOVE, 31'd12345);
        send_request(CMD_NOP, '0);
        wait_drained();
    endtask

    task automatic run_random(input int n_items);
        int add_pct;
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  wid;
        add_pct = 45;
        for (int k = 0; k < n_items; k++) begin
            // sweep occupancy between empty and full in stretches
            if (k % 40 == 0)
                case ($urandom_range(2))
                    0:       add_pct = 20;
                    1:       add_pct = 45;
                    default: add_pct = 75;
                endcase
            wid = random_id();
            if ($urandom_range(99) < 3) begin
                cmd = CMD_NOP;
            end else begin
                roll = $urandom_range(99);
                if (roll < add_pct)
                    cmd = CMD_ADD;
                else if (roll < add_pct + (100 - add_pct) / 2)
                    cmd = CMD_REMOVE;
                else
                    cmd = CMD_ALLOC;
            end
            if (cmd == CMD_REMOVE && pool_ids.size() != 0 && $urandom_range(99) < 80)
                wid = pool_ids[$urandom_range(pool_ids.size() - 1)];
            send_request(cmd, wid);
        end
        wait_drained();
    endtask

    task automatic test_random_slow_receiver();
        src_idle_pct = 8;
        snk_idle_pct = 84;
        run_random(560);
    endtask

    task automatic test_random_slow_sender();
        src_idle_pct = 84;
        snk_idle_pct = 8;
        run_random(560);
    endtask

    task automatic test_random_no_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(580);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_no_idle();
        // watch for stray results
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS ordered_worker_pool_allocator");
        end else begin
            $display("FAIL ordered_worker_pool_allocator");
        end
        $finish;
    end

endmodule : ordered_worker_pool_allocator_test
